[src/bitmap_frame_allocator_unit_macros.svh]
// Assertion macros for the frame allocator.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BFA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfa: assertion failed");
// next-cycle implication
`define BFA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfa: assertion failed");
`else
`define BFA_ASSERT_IMP(label, clk, rst, ante, cons)
`define BFA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[src/bfa_pkg.sv]
// Shared types, constants and helpers for the bitmap frame allocator.
// No dependencies.
package bfa_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = MAX_FRAMES / WORD_BITS;
  localparam int FRAME_W    = 12;
  localparam int BIT_W      = 6;
  localparam int WADDR_W    = FRAME_W - BIT_W;
  localparam int COUNT_W    = 13;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [WADDR_W-1:0]   waddr_t;
  typedef logic [BIT_W-1:0]     bidx_t;

  typedef enum logic [1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_FREE      = 2'd1,
    CMD_MARK_FREE = 2'd2,
    CMD_MARK_USED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  // register index, taken from paddr above the byte offset
  localparam logic REG_FRAME_LIMIT = 1'b0;

  localparam count_t COUNT_FULL = COUNT_W'(MAX_FRAMES);

  // bitmap write request
  typedef struct packed {
    logic   en;
    waddr_t addr;
    word_t  data;
  } mem_wr_t;

  typedef struct packed {
    logic  hit;
    bidx_t idx;
  } find_t;

  // lowest set bit of a word
  function automatic find_t first_set(input word_t w);
    find_t r;
    r.hit = |w;
    r.idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r.idx = bidx_t'(i);
      end
    end
    return r;
  endfunction

endpackage

[src/bfa_if.sv]
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on bfa_pkg.
interface bfa_req_if;
  logic            valid;
  logic            ready;
  bfa_pkg::cmd_t   cmd;
  bfa_pkg::frame_t frame;
  modport source (output valid, cmd, frame, input ready);
  modport sink   (input valid, cmd, frame, output ready);
endinterface

interface bfa_rsp_if;
  logic             valid;
  logic             ready;
  bfa_pkg::status_t status;
  bfa_pkg::frame_t  alloc_frame;
  bfa_pkg::count_t  used_count;
  modport source (output valid, status, alloc_frame, used_count, input ready);
  modport sink   (input valid, status, alloc_frame, used_count, output ready);
endinterface

[src/bitmap_frame_allocator_unit.sv]
// Bitmap physical frame allocator with next-fit search.
// Depends on bfa_pkg, bfa_if, bfa_bitmap and the assertion macro header.
//
// Usage:
//  - req carries one command word (cmd, frame); rsp returns one word per
//    command (status, alloc_frame, used_count). Both are valid/ready.
//  - APB register 0 (byte address 0) is frame_limit, the highest frame
//    searched; write it only while the block is idle. pready is tied high.
//  - In-range free and mark commands pass through a bitmap read, a
//    read-modify-write and the load of the output register before rsp.valid.
//  - Alloc first reduces hint+1 modulo limit+1 (done at acceptance when the
//    hint is below the limit, else by a shift-subtract remainder in S_MOD),
//    then scans one 64-bit bitmap word a cycle from the start word, wrapping
//    at the limit.
//  - One command is in work at a time; req.ready is low until its
//    response has been handed to the output register.
//  - Reset marks every frame used (count 4096), hint 0, limit 4095.
//    No clearing pass is needed.
//  - A stalled rsp holds its word; the next command may be accepted
//    meanwhile and its result waits until the output register frees.
`include "bitmap_frame_allocator_unit_macros.svh"
module bitmap_frame_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  bfa_req_if.sink                     req,
  bfa_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfa_pkg::PADDR_W-1:0] paddr,
  input  logic [bfa_pkg::PDATA_W-1:0] pwdata,
  output logic [bfa_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import bfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_START,
    S_SCAN,
    S_READ,
    S_UPDATE,
    S_RESP
  } state_t;

  state_t  state;
  frame_t  frame_limit;
  frame_t  hint;
  count_t  used_count;
  cmd_t    cmd_q;
  frame_t  frame_q;
  count_t  dividend;
  frame_t  rem;
  logic [3:0] bitcnt;
  frame_t  pos;
  waddr_t  iw;
  logic    iphase;
  logic    issuing;
  waddr_t  rword;
  logic    rphase;
  logic    rlast;
  logic    rvld;
  status_t res_status;
  frame_t  res_frame;
  logic    out_valid;
  status_t out_status;
  frame_t  out_frame;
  count_t  out_count;

  mem_wr_t wr;
  waddr_t  raddr;
  word_t   rdata;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_FRAME_LIMIT) ?
                  PDATA_W'(frame_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= frame_t'(MAX_FRAMES - 1);
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_FRAME_LIMIT) begin
      frame_limit <= pwdata[FRAME_W-1:0];
    end
  end

  // bitmap
  bfa_bitmap u_bitmap (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign raddr = (state == S_SCAN) ? iw : frame_q[FRAME_W-1:BIT_W];

  // search window
  count_t n_frames;
  count_t start_sum;
  waddr_t ws;
  waddr_t wl;
  assign n_frames  = {1'b0, frame_limit} + count_t'(1);
  assign start_sum = {1'b0, hint} + count_t'(1);
  assign ws = pos[FRAME_W-1:BIT_W];
  assign wl = frame_limit[FRAME_W-1:BIT_W];

  // remainder step: shift in one dividend bit, subtract if it fits
  count_t rem_sh;
  count_t rem_sub;
  logic   rem_fits;
  assign rem_sh   = {rem, dividend[bitcnt]};
  assign rem_fits = rem_sh >= n_frames;
  assign rem_sub  = rem_fits ? (rem_sh - n_frames) : rem_sh;

  // word check: mask out frames outside this part of the circular window
  word_t ge_mask;
  word_t le_mask;
  word_t win_mask;
  word_t cand;
  find_t hit;
  always_comb begin
    ge_mask  = '1 << pos[BIT_W-1:0];
    le_mask  = '1 >> (bidx_t'(WORD_BITS - 1) - frame_limit[BIT_W-1:0]);
    win_mask = '1;
    if (!rphase) begin
      if (rword == ws) win_mask = win_mask & ge_mask;
      if (rword == wl) win_mask = win_mask & le_mask;
    end else if (rword == ws) begin
      win_mask = ~ge_mask;
    end
    cand = ~rdata & win_mask;
    hit  = first_set(cand);
  end

  // single-frame bit for free and mark commands
  logic  cur_bit;
  word_t fbit;
  assign cur_bit = rdata[frame_q[BIT_W-1:0]];
  assign fbit    = word_t'(1) << frame_q[BIT_W-1:0];

  // bitmap write-back
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = frame_q[FRAME_W-1:BIT_W];
    wr.data = rdata | fbit;
    if (state == S_SCAN && rvld && hit.hit) begin
      wr.en   = 1'b1;
      wr.addr = rword;
      wr.data = rdata | (word_t'(1) << hit.idx);
    end else if (state == S_UPDATE) begin
      case (cmd_q)
        CMD_FREE:      begin wr.en = cur_bit;  wr.data = rdata & ~fbit; end
        CMD_MARK_FREE: begin wr.en = cur_bit;  wr.data = rdata & ~fbit; end
        CMD_MARK_USED: begin wr.en = !cur_bit; wr.data = rdata | fbit;  end
        default:       wr.en = 1'b0;
      endcase
    end
  end

  count_t count_inc;
  count_t count_dec;
  assign count_inc = (used_count < COUNT_FULL) ? used_count + count_t'(1) : used_count;
  assign count_dec = (used_count != '0) ? used_count - count_t'(1) : used_count;

  logic out_load;
  assign out_load  = (state == S_RESP) && (!out_valid || rsp.ready);
  assign req.ready = (state == S_IDLE);

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.alloc_frame = out_frame;
  assign rsp.used_count  = out_count;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hint       <= '0;
      used_count <= COUNT_FULL;
      issuing    <= 1'b0;
      rvld       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q   <= req.cmd;
            frame_q <= req.frame;
            if (req.cmd == CMD_ALLOC) begin
              dividend <= start_sum;
              rem      <= '0;
              bitcnt   <= 4'(COUNT_W - 1);
              if (start_sum < n_frames) begin
                pos   <= start_sum[FRAME_W-1:0];
                state <= S_START;
              end else begin
                state <= S_MOD;
              end
            end else if (req.frame > frame_limit) begin
              res_status <= ST_RANGE;
              res_frame  <= '0;
              state      <= S_RESP;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_MOD: begin
          rem    <= rem_sub[FRAME_W-1:0];
          bitcnt <= bitcnt - 4'd1;
          if (bitcnt == '0) begin
            pos   <= rem_sub[FRAME_W-1:0];
            state <= S_START;
          end
        end
        S_START: begin
          iw      <= ws;
          iphase  <= 1'b0;
          issuing <= 1'b1;
          rvld    <= 1'b0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          // issue side: words ws..wl, then 0..ws
          rword <= iw;
          rphase <= iphase;
          rlast <= iphase && (iw == ws);
          rvld  <= issuing;
          if (!iphase) begin
            if (iw == wl) begin
              iphase <= 1'b1;
              iw     <= '0;
            end else begin
              iw <= iw + waddr_t'(1);
            end
          end else if (iw == ws) begin
            issuing <= 1'b0;
          end else begin
            iw <= iw + waddr_t'(1);
          end
          // check side
          if (rvld && hit.hit) begin
            used_count <= count_inc;
            hint       <= {rword, hit.idx};
            res_status <= ST_OK;
            res_frame  <= {rword, hit.idx};
            issuing    <= 1'b0;
            rvld       <= 1'b0;
            state      <= S_RESP;
          end else if (rvld && rlast) begin
            res_status <= ST_OOM;
            res_frame  <= '0;
            issuing    <= 1'b0;
            rvld       <= 1'b0;
            state      <= S_RESP;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          res_status <= ST_OK;
          res_frame  <= '0;
          case (cmd_q)
            CMD_FREE: begin
              if (!cur_bit) res_status <= ST_DOUBLE;
              else          used_count <= count_dec;
            end
            CMD_MARK_FREE: begin
              if (cur_bit) used_count <= count_dec;
            end
            CMD_MARK_USED: begin
              if (!cur_bit) used_count <= count_inc;
            end
            default: res_status <= ST_OK;
          endcase
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_frame  <= res_frame;
            out_count  <= used_count;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `BFA_ASSERT_IMP(a_err_no_frame, clk, rst, rsp.valid && rsp.status != ST_OK, rsp.alloc_frame == '0)
  `BFA_ASSERT_NXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  `BFA_ASSERT_NXT(a_hint_follows_grant, clk, rst, out_load && res_status == ST_OK && cmd_q == CMD_ALLOC, hint == rsp.alloc_frame)

endmodule

[src/bfa_bitmap.sv]
// Used-frame bitmap: 64 words of 64 bits, one write and one registered read a cycle.
// Depends on bfa_pkg. Words never written read as all ones (every frame used).
module bfa_bitmap (
  input  logic             clk,
  input  logic             rst,
  input  bfa_pkg::mem_wr_t wr,
  input  bfa_pkg::waddr_t  raddr,
  output bfa_pkg::word_t   rdata
);
  import bfa_pkg::*;

  word_t                mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] written;
  word_t                rdata_q;
  logic                 rwritten_q;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_q <= mem[raddr];
  end

  // per-word written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rwritten_q <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      rwritten_q <= written[raddr];
    end
  end

  assign rdata = rwritten_q ? rdata_q : '1;

endmodule

[test/bitmap_frame_allocator_unit_test.sv]
`timescale 1ns / 1ps
// Testbench for bitmap_frame_allocator_unit: a directed table, then phases of random command
// words under several frame limits. Each reply must match its typed row or a next-fit model.
// Depends on bfa_pkg, bfa_if and the allocator RTL.
module bitmap_frame_allocator_unit_test;
  import bfa_pkg::*;

  localparam int STUCK_LIMIT    = 2000;  // cycles with no handshake
  localparam int LONG_HOLD      = 300;
  localparam int PHASES         = 9;
  localparam int PHASE_WORDS    = 150;
  localparam int PRESSURE_PHASE = 5;
  localparam int ROWS           = 26;

  typedef struct packed {
    status_t status;
    frame_t  alloc_frame;
    count_t  used_count;
  } reply_t;

  typedef struct packed {
    bit     cfg;    // row writes frame_limit instead of sending a word
    frame_t lim;
    cmd_t   cmd;
    frame_t frame;
    bit     typed;  // reply below is the expected one
    reply_t want;
  } row_t;

  localparam reply_t UNTYPED = '{ST_OK, 12'd0, 13'd0};

  // directed words: extremes, every command, each error and the hint beyond the limit
  row_t plan [ROWS] = '{
    '{1'b0, 12'd0,    CMD_ALLOC,     12'd0,    1'b1, '{ST_OOM,    12'd0,    13'd4096}},
    '{1'b0, 12'd0,    CMD_FREE,      12'd0,    1'b1, '{ST_OK,     12'd0,    13'd4095}},
    '{1'b0, 12'd0,    CMD_FREE,      12'd0,    1'b1, '{ST_DOUBLE, 12'd0,    13'd4095}},
    '{1'b0, 12'd0,    CMD_MARK_FREE, 12'd4095, 1'b1, '{ST_OK,     12'd0,    13'd4094}},
    '{1'b0, 12'd0,    CMD_MARK_FREE, 12'd4095, 1'b1, '{ST_OK,     12'd0,    13'd4094}},
    '{1'b0, 12'd0,    CMD_ALLOC,     12'd0,    1'b1, '{ST_OK,     12'd4095, 13'd4095}},
    '{1'b0, 12'd0,    CMD_ALLOC,     12'd0,    1'b1, '{ST_OK,     12'd0,    13'd4096}},
    '{1'b0, 12'd0,    CMD_ALLOC,     12'd0,    1'b1, '{ST_OOM,    12'd0,    13'd4096}},
    '{1'b0, 12'd0,    CMD_MARK_USED, 12'd4095, 1'b1, '{ST_OK,     12'd0,    13'd4096}},
    '{1'b0, 12'd0,    CMD_MARK_FREE, 12'hAAA,  1'b0, UNTYPED},
    '{1'b0, 12'd0,    CMD_MARK_FREE, 12'h555,  1'b0, UNTYPED},
    '{1'b0, 12'd0,    CMD_ALLOC,     12'hFFF,  1'b0, UNTYPED},
    '{1'b0, 12'd0,    CMD_MARK_USED, 12'hAAA,  1'b0, UNTYPED},
    '{1'b1, 12'd0,    CMD_ALLOC,     12'd0,    1'b0, UNTYPED},
    '{1'b0, 12'd0,    CMD_MARK_FREE, 12'd1,    1'b1, '{ST_RANGE,  12'd0,    13'd4096}},
    '{1'b0, 12'd0,    CMD_FREE,      12'd4095, 1'b1, '{ST_RANGE,  12'd0,    13'd4096}},
    '{1'b0, 12'd0,    CMD_MARK_USED, 12'd4095, 1'b1, '{ST_RANGE,  12'd0,    13'd4096}},
    '{1'b0, 12'd0,    CMD_MARK_FREE, 12'd0,    1'b0, UNTYPED},
    '{1'b0, 12'd0,    CMD_ALLOC,     12'd0,    1'b0, UNTYPED},
    '{1'b0, 12'd0,    CMD_ALLOC,     12'd0,    1'b0, UNTYPED},
    '{1'b1, 12'd4095, CMD_ALLOC,     12'd0,    1'b0, UNTYPED},
    '{1'b0, 12'd0,    CMD_MARK_FREE, 12'd3000, 1'b0, UNTYPED},
    '{1'b0, 12'd0,    CMD_ALLOC,     12'd0,    1'b0, UNTYPED},
    '{1'b1, 12'd63,   CMD_ALLOC,     12'd0,    1'b0, UNTYPED},
    '{1'b0, 12'd0,    CMD_MARK_FREE, 12'd5,    1'b0, UNTYPED},
    '{1'b0, 12'd0,    CMD_ALLOC,     12'd0,    1'b0, UNTYPED}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bfa_req_if cmd_ch ();
  bfa_rsp_if reply_ch ();

  // allocator state as predicted
  word_t       used_map [NUM_WORDS];
  int unsigned in_use;
  frame_t      hint;
  frame_t      limit_reg;

  reply_t reply_q [$];   // replies owed by the block, oldest first
  bit     row_typed;
  reply_t row_want;
  bit     cmd_taken;     // a word was accepted at the last rising edge
  bit     quiet = 1'b0;  // no idling on either side
  int     stall_asked = 0;
  int     fault_count = 0;
  int     words_sent = 0;
  int     limit_writes = 0;
  int     stuck_cycles = 0;
  int     status_tally [4];

  bitmap_frame_allocator_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (cmd_ch),
    .rsp     (reply_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void note_fault(input string what);
    fault_count++;
    if (fault_count <= 10) $display("MISMATCH: %s", what);
  endfunction

  function automatic bit frame_used(input int unsigned f);
    return used_map[f / WORD_BITS][f % WORD_BITS];
  endfunction

  // set or clear one frame bit, keeping the count equal to the bits set
  function automatic void set_frame(input int unsigned f, input bit u);
    if (used_map[f / WORD_BITS][f % WORD_BITS] != u) begin
      used_map[f / WORD_BITS][f % WORD_BITS] = u;
      if (u) in_use++;
      else in_use--;
    end
  endfunction

  // next-fit allocator: works out the reply to one command word and updates the state
  function automatic reply_t apply_command(input cmd_t c, input frame_t f);
    reply_t      r;
    int unsigned n;
    int unsigned pos;
    int unsigned tries;
    r = '{ST_OK, '0, '0};
    n = int'(limit_reg) + 1;
    if (c == CMD_ALLOC) begin
      // circular search from hint + 1, taken modulo limit + 1
      pos = (int'(hint) + 1) % n;
      tries = 0;
      while (tries < n && frame_used(pos)) begin
        pos = (pos + 1 == n) ? 0 : pos + 1;
        tries++;
      end
      if (tries < n) begin
        set_frame(pos, 1'b1);
        hint = frame_t'(pos);
        r.alloc_frame = frame_t'(pos);
      end else begin
        r.status = ST_OOM;
      end
    end else if (f > limit_reg) begin
      r.status = ST_RANGE;
    end else if (c == CMD_FREE) begin
      if (!frame_used(f)) r.status = ST_DOUBLE;
      else set_frame(f, 1'b0);
    end else begin
      set_frame(f, c == CMD_MARK_USED);
    end
    r.used_count = count_t'(in_use);
    return r;
  endfunction

  // offer one command word and wait until it is taken
  task automatic push_word(input cmd_t c, input frame_t f, input bit typed, input reply_t want);
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= c;
    cmd_ch.frame <= f;
    row_typed = typed;
    row_want  = want;
    do @(negedge clk); while (!cmd_taken);
  endtask

  // stop offering and wait for every owed reply
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (reply_q.size() != 0);
  endtask

  // write frame_limit once idle, then read it back
  task automatic set_limit(input frame_t v);
    logic [PDATA_W-1:0] rd;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FRAME_LIMIT, 2'b00};
    pwdata  <= PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    limit_reg = v;
    limit_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== PDATA_W'(v)) begin
      note_fault($sformatf("frame_limit read back %0h, wrote %0h", rd, v));
    end
  endtask

  // check replies against the oldest owed one, then predict the accepted word
  always @(posedge clk) begin : reply_check
    reply_t want;
    reply_t got;
    reply_t model;
    if (rst) begin
      cmd_taken = 1'b0;
    end else begin
      cmd_taken = cmd_ch.valid && cmd_ch.ready;
      if (reply_ch.valid && reply_ch.ready) begin
        got = '{reply_ch.status, reply_ch.alloc_frame, reply_ch.used_count};
        if (reply_q.size() == 0) begin
          note_fault($sformatf("reply status %0d frame %0d count %0d with none owed",
                               got.status, got.alloc_frame, got.used_count));
        end else begin
          want = reply_q.pop_front();
          status_tally[want.status]++;
          if (got !== want) begin
            note_fault($sformatf({"expected status %0d frame %0d count %0d, ",
                                  "got status %0d frame %0d count %0d"},
                                 want.status, want.alloc_frame, want.used_count,
                                 got.status, got.alloc_frame, got.used_count));
          end
        end
      end
      if (cmd_taken) begin
        model = apply_command(cmd_ch.cmd, cmd_ch.frame);
        reply_q.push_back(row_typed ? row_want : model);
        words_sent++;
      end
    end
  end

  // watchdog on handshakes of any kind
  always @(posedge clk) begin : stuck_guard
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (reply_ch.valid && reply_ch.ready) || psel) begin
      stuck_cycles = 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles++;
    end
  end

  // reply side: bursts of back-pressure, one long hold on request
  initial begin : reply_taker
    int seen;
    seen = 0;
    reply_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asked != seen) begin
        seen++;
        reply_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        reply_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        reply_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24) - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int     roll;
    frame_t lim;
    cmd_t   c;
    frame_t f;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd   = CMD_ALLOC;
    cmd_ch.frame = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    for (int w = 0; w < NUM_WORDS; w++) used_map[w] = '1;
    in_use    = MAX_FRAMES;
    hint      = '0;
    limit_reg = '1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].cfg) set_limit(plan[i].lim);
      else push_word(plan[i].cmd, plan[i].frame, plan[i].typed, plan[i].want);
    end

    // random phases, each under its own frame limit
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: lim = 12'd63;
        1: lim = '1;
        2: lim = '0;
        3: lim = frame_t'($urandom_range(1, 255));
        4: lim = 12'd64;
        5: lim = frame_t'($urandom);
        6: lim = frame_t'($urandom_range(100, 600));
        7: lim = '1;
        default: lim = 12'd31;
      endcase
      set_limit(lim);
      if (p == PRESSURE_PHASE) stall_asked <= stall_asked + 1;
      if (p == PHASES - 1) quiet <= 1'b1;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // mostly in-range frees and marks around allocs, some noise
        roll = $urandom_range(0, 99);
        f = frame_t'($urandom_range(0, lim));
        if (roll < 40) begin
          c = CMD_ALLOC;
          f = frame_t'($urandom);
        end else if (roll < 62) begin
          c = CMD_FREE;
        end else if (roll < 82) begin
          c = CMD_MARK_FREE;
        end else if (roll < 90) begin
          c = CMD_MARK_USED;
        end else begin
          c = cmd_t'($urandom_range(0, 3));
          f = frame_t'($urandom);
        end
        push_word(c, f, 1'b0, UNTYPED);
        if (p == PRESSURE_PHASE && k == PHASE_WORDS / 2) begin
          settle();
        end else if (p != PRESSURE_PHASE && p != PHASES - 1 && (k / 25) % 2 == 0
                     && $urandom_range(0, 4) == 0) begin
          cmd_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 7)) @(negedge clk);
        end
      end
    end

    settle();
    repeat (100) @(negedge clk);
    $display("Covered %0d command words under %0d frame limit settings, 0 and 4095 included.",
             words_sent, limit_writes);
    $display("Replies: %0d ok, %0d out of memory, %0d double free, %0d above limit.",
             status_tally[ST_OK], status_tally[ST_OOM], status_tally[ST_DOUBLE],
             status_tally[ST_RANGE]);
    if (fault_count == 0 && reply_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d faults, %0d replies still owed", fault_count, reply_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/bfa_pkg.sv
src/bfa_if.sv
src/bfa_bitmap.sv
src/bitmap_frame_allocator_unit.sv
test/bitmap_frame_allocator_unit_test.sv
